/* rtl/decimal_string_bounded_parser_unit_assert.svh */
// Assertion macros for the parser top level.
`ifndef DECIMAL_STRING_BOUNDED_PARSER_UNIT_ASSERT_SVH
`define DECIMAL_STRING_BOUNDED_PARSER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DSBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DSBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/dsbp_pkg.sv */
// Types, codes and limit digit table for the bounded decimal parser.
`timescale 1ns / 1ps
`default_nettype none

package dsbp_pkg;

    typedef enum logic [1:0] {
        PH_ENDED = 2'd0,
        PH_FIRST = 2'd1,
        PH_READ  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_GT = 2'd1,
        CMP_LT = 2'd2
    } t_cmp;

    typedef enum logic [1:0] {
        ST_DIGIT   = 2'd0,
        ST_DONE    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef struct packed {
        t_phase      phase;
        t_cmp        cmp;
        logic [3:0]  idx;
        logic [31:0] value;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{PH_ENDED, CMP_EQ, 4'd0, 32'd0};
    localparam t_parse_state STATE_START = '{PH_FIRST, CMP_EQ, 4'd0, 32'd0};

    localparam logic [7:0] CHAR_NUL  = 8'd0;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    localparam logic [3:0] LAST_POS_BIG   = 4'd9;
    localparam logic [3:0] LAST_POS_SMALL = 4'd1;

    localparam logic REG_LIMIT_SELECT = 1'b0;

    // Digit of 4294967295 or 31 at the given position.
    function automatic logic [3:0] lim_digit(input logic sel, input logic [3:0] pos);
        logic [3:0] d;
        if (sel) begin
            d = pos[0] ? 4'd1 : 4'd3;
        end else begin
            unique case (pos)
                4'd0:    d = 4'd4;
                4'd1:    d = 4'd2;
                4'd2:    d = 4'd9;
                4'd3:    d = 4'd4;
                4'd4:    d = 4'd9;
                4'd5:    d = 4'd6;
                4'd6:    d = 4'd7;
                4'd7:    d = 4'd2;
                4'd8:    d = 4'd9;
                4'd9:    d = 4'd5;
                default: d = 4'd0;
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/dsbp_step.sv */
// Next-state and status logic for one character of the parser.
`timescale 1ns / 1ps
`default_nettype none

module dsbp_step (
    input  wire dsbp_pkg::t_parse_state i_state,
    input  wire logic [7:0]             i_char,
    input  wire logic                   i_start,
    input  wire logic                   i_limit_sel,
    output dsbp_pkg::t_parse_state      o_state,
    output dsbp_pkg::t_status           o_status,
    output logic [3:0]                  o_pos
);

    dsbp_pkg::t_parse_state st;
    dsbp_pkg::t_cmp         cmp_next;
    logic [7:0]             char_off;
    logic [3:0]             digit;
    logic [3:0]             lim_d;
    logic [3:0]             last_pos;
    logic                   is_digit;
    logic                   in_range;
    logic                   active;

    always_comb begin
        st       = i_start ? dsbp_pkg::STATE_START : i_state;
        char_off = i_char - dsbp_pkg::CHAR_ZERO;
        digit    = char_off[3:0];
        is_digit = (i_char >= dsbp_pkg::CHAR_ZERO) && (i_char <= dsbp_pkg::CHAR_NINE);
        lim_d    = dsbp_pkg::lim_digit(i_limit_sel, st.idx);
        last_pos = i_limit_sel ? dsbp_pkg::LAST_POS_SMALL : dsbp_pkg::LAST_POS_BIG;
        active   = (st.phase == dsbp_pkg::PH_FIRST) || (st.phase == dsbp_pkg::PH_READ);

        cmp_next = st.cmp;
        if (st.idx < last_pos) begin
            in_range = 1'b1;
            if (st.cmp == dsbp_pkg::CMP_EQ) begin
                if (digit > lim_d) begin
                    cmp_next = dsbp_pkg::CMP_GT;
                end else if (digit < lim_d) begin
                    cmp_next = dsbp_pkg::CMP_LT;
                end
            end
        end else if (st.idx == last_pos) begin
            in_range = !((st.cmp == dsbp_pkg::CMP_GT) ||
                         ((st.cmp == dsbp_pkg::CMP_EQ) && (digit > lim_d)));
        end else begin
            in_range = 1'b0;
        end

        o_state = st;
        o_pos   = st.idx;
        if (!active) begin
            o_status = dsbp_pkg::ST_IGNORED;
        end else if (is_digit) begin
            if (((st.phase == dsbp_pkg::PH_FIRST) && (digit == 4'd0)) || !in_range) begin
                o_status      = dsbp_pkg::ST_REJECT;
                o_state.phase = dsbp_pkg::PH_ENDED;
            end else begin
                o_status      = dsbp_pkg::ST_DIGIT;
                o_state.phase = dsbp_pkg::PH_READ;
                o_state.cmp   = cmp_next;
                o_state.idx   = st.idx + 4'd1;
                o_state.value = (st.value << 3) + (st.value << 1) + {28'd0, digit};
            end
        end else if ((i_char == dsbp_pkg::CHAR_NUL) && (st.phase == dsbp_pkg::PH_READ)) begin
            o_status      = dsbp_pkg::ST_DONE;
            o_state.phase = dsbp_pkg::PH_ENDED;
        end else begin
            o_status      = dsbp_pkg::ST_REJECT;
            o_state.phase = dsbp_pkg::PH_ENDED;
        end
    end

endmodule

`default_nettype wire

/* rtl/decimal_string_bounded_parser_unit.sv */
// Top level of the bounded decimal string parser.
//
//  channel  | direction | handshake            | payload
//  s stream | in        | i_s_tvalid/o_s_tready | tdata char_code, tuser start_number
//  m stream | out       | o_m_tvalid/i_m_tready | tdata value+position, tuser status
//  apb      | in        | psel/penable/pready   | limit_select at address 0
//
// One word per cycle sustained while results are taken; each word passes the input register
// and leaves through the result register.
// The running state is updated by one multiply-by-ten add and a digit compare per word.
// Synchronous active-low reset clears the pipeline, the parse state and limit_select.
// A stalled result holds and the input register still takes one word behind it.
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_string_bounded_parser_unit_assert.svh"

module decimal_string_bounded_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire logic [0:0]  i_s_tuser,   // [0] start_number
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [31:0] value, [35:32] position, zero above
    output logic [1:0]       o_m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                   r_in_valid;
    logic [7:0]             r_in_char;
    logic                   r_in_start;
    logic                   r_limit_sel;
    dsbp_pkg::t_parse_state r_state;
    logic                   r_out_valid;
    dsbp_pkg::t_status      r_out_status;
    logic [31:0]            r_out_value;
    logic [3:0]             r_out_pos;

    dsbp_pkg::t_parse_state n_state;
    dsbp_pkg::t_status      n_status;
    logic [3:0]             n_pos;
    logic                   advance;
    logic                   cfg_write;
    logic                   took_digit;
    logic                   done_out;

    dsbp_step u_step (
        .i_state     (r_state),
        .i_char      (r_in_char),
        .i_start     (r_in_start),
        .i_limit_sel (r_limit_sel),
        .o_state     (n_state),
        .o_status    (n_status),
        .o_pos       (n_pos)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign cfg_write  = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dsbp_pkg::REG_LIMIT_SELECT) ? {31'd0, r_limit_sel} : 32'd0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_pos, r_out_value};
    assign o_m_tuser  = r_out_status;

    assign took_digit = advance && (n_status == dsbp_pkg::ST_DIGIT);
    assign done_out   = r_out_valid && (r_out_status == dsbp_pkg::ST_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit_sel <= 1'b0;
            r_state     <= dsbp_pkg::STATE_RESET;
        end else begin
            if (cfg_write && (paddr[2] == dsbp_pkg::REG_LIMIT_SELECT)) begin
                r_limit_sel <= pwdata[0];
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char  <= i_s_tdata;
            r_in_start <= i_s_tuser[0];
        end
        if (advance) begin
            r_out_status <= n_status;
            r_out_value  <= n_state.value;
            r_out_pos    <= n_pos;
        end
    end

    `DSBP_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !r_out_valid, "valid after reset")
    `DSBP_ASSERT(a_stall_hold, (r_in_valid && !advance) |-> !o_s_tready, "stall took input")
    `DSBP_ASSERT(a_digit_rd, took_digit |=> (r_state.phase == dsbp_pkg::PH_READ), "not reading")
    `DSBP_ASSERT(a_done_nonzero, done_out |-> (r_out_value != 32'd0), "zero number done")

endmodule

`default_nettype wire
